// ===== design/vei_pkg.sv =====
// Shared types and constants for the velocity estimator.
// Holds the beat structs, datapath widths and the Q2.30 filter taps.
// No dependencies.
package vei_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int NUM_AXES   = 3;
    localparam int DIFF_SCALE = 500;
    localparam int DIFF_W     = SAMPLE_W + 3;
    localparam int RAW_W      = DIFF_W + $clog2(DIFF_SCALE);
    localparam int COEF_W     = 33;
    localparam int COEF_SHIFT = 30;
    localparam int PROD_W     = RAW_W + 1 + COEF_W;
    localparam int ACC_W      = 48;

    // Q2.30 taps; the feed-forward taps carry the 1/1000 scale
    localparam logic signed [COEF_W-1:0] COEF_A  = 33'sd235794;
    localparam logic signed [COEF_W-1:0] COEF_B  = 33'sd707381;
    localparam logic signed [COEF_W-1:0] COEF_G1 = 33'sd2951501526;
    localparam logic signed [COEF_W-1:0] COEF_G2 = 33'sd2714634079;
    localparam logic signed [COEF_W-1:0] COEF_G3 = 33'sd834941642;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RAW_W-1:0]    raw_t;

    typedef struct packed {
        sample_t pos_x;
        sample_t pos_y;
        sample_t pos_z;
    } vei_in_t;

    typedef struct packed {
        sample_t vel_x;
        sample_t vel_y;
        sample_t vel_z;
    } vei_out_t;

endpackage

// ===== design/vei_diff.sv =====
// One axis of the backward-difference stage: raw = (3p - 4p1 + p2) * 500.
// Keeps the two previous samples and registers the raw velocity.
// Depends on vei_pkg.
module vei_diff (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  vei_pkg::sample_t pos,
    output vei_pkg::raw_t  raw
);
    import vei_pkg::*;

    sample_t                  p1_reg;
    sample_t                  p2_reg;
    raw_t                     raw_reg;
    logic signed [DIFF_W-1:0] diff;
    raw_t                     raw_next;

    always_comb
    begin
        diff = (DIFF_W'(pos) <<< 1) + DIFF_W'(pos) - (DIFF_W'(p1_reg) <<< 2)
             + DIFF_W'(p2_reg);
        raw_next = RAW_W'(diff) * RAW_W'(DIFF_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else if (en)
        begin
            p2_reg <= p1_reg;
            p1_reg <= pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw = raw_reg;

endmodule

// ===== design/vei_filt.sv =====
// One axis of the third-order IIR filter on the raw velocity.
// Five rounded Q2.30 products, a 48-bit sum and saturation; the output
// register doubles as the first feedback tap. Depends on vei_pkg.
module vei_filt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  vei_pkg::raw_t    raw,
    output vei_pkg::sample_t vel
);
    import vei_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (COEF_SHIFT - 1);

    raw_t    raw1_reg;
    raw_t    raw2_reg;
    raw_t    raw3_reg;
    sample_t y1_reg;
    sample_t y2_reg;
    sample_t y3_reg;

    logic signed [RAW_W:0]    sum_a;
    logic signed [RAW_W:0]    sum_b;
    logic signed [ACC_W-1:0]  term_a;
    logic signed [ACC_W-1:0]  term_b;
    logic signed [ACC_W-1:0]  term_g1;
    logic signed [ACC_W-1:0]  term_g2;
    logic signed [ACC_W-1:0]  term_g3;
    logic signed [ACC_W-1:0]  acc;
    logic                     fits;
    sample_t                  y_next;

    // shift right by 30, rounding half away from zero
    function automatic logic signed [ACC_W-1:0] q30_round(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] q;
        t = p + HALF_P - {{(PROD_W-1){1'b0}}, p[PROD_W-1]};
        q = t >>> COEF_SHIFT;
        return q[ACC_W-1:0];
    endfunction

    always_comb
    begin
        sum_a   = (RAW_W+1)'(raw) + (RAW_W+1)'(raw3_reg);
        sum_b   = (RAW_W+1)'(raw1_reg) + (RAW_W+1)'(raw2_reg);
        term_a  = q30_round(PROD_W'(sum_a) * PROD_W'(COEF_A));
        term_b  = q30_round(PROD_W'(sum_b) * PROD_W'(COEF_B));
        term_g1 = q30_round(PROD_W'(y1_reg) * PROD_W'(COEF_G1));
        term_g2 = q30_round(PROD_W'(y2_reg) * PROD_W'(COEF_G2));
        term_g3 = q30_round(PROD_W'(y3_reg) * PROD_W'(COEF_G3));
        acc     = term_a + term_b + term_g1 - term_g2 + term_g3;
        // in range when all bits above the sample sign match it
        fits    = (acc[ACC_W-1:SAMPLE_W-1] == '0) || (acc[ACC_W-1:SAMPLE_W-1] == '1);
        y_next  = fits ? acc[SAMPLE_W-1:0]
                       : {acc[ACC_W-1], {(SAMPLE_W-1){~acc[ACC_W-1]}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw1_reg <= '0;
            raw2_reg <= '0;
            raw3_reg <= '0;
            y1_reg   <= '0;
            y2_reg   <= '0;
            y3_reg   <= '0;
        end
        else if (en)
        begin
            raw3_reg <= raw2_reg;
            raw2_reg <= raw1_reg;
            raw1_reg <= raw;
            y3_reg   <= y2_reg;
            y2_reg   <= y1_reg;
            y1_reg   <= y_next;
        end
    end

    assign vel = y1_reg;

endmodule

// ===== design/velocity_estimate_iir.sv =====
// Velocity estimator: per-axis backward difference and third-order IIR filter.
//
// Input channel pos_*: one beat carries a 3-axis Q16.16 position sample
// (pos_data). A beat is taken at a rising edge with pos_valid high and
// pos_stall low. Output channel vel_*: one beat per input beat with the
// filtered Q16.16 velocity of each axis, saturated to 32 bits.
// A taken sample passes the input, difference and result registers in turn
// before it shows on vel_valid. Throughput: one sample per cycle sustained
// while vel_stall is low. The filter feedback closes through the first tap
// multiply, the five-term sum and saturation back into the output register.
// A stall on vel_stall holds the result register and backs up the two
// earlier stages; pos_stall rises only when the input register cannot move.
// Reset clears all position, raw-velocity and output history to zero and
// empties the pipeline. Axes at or above AXES read zero and ignore input.
// Depends on vei_pkg, vei_diff and vei_filt.
module velocity_estimate_iir #(
    parameter int AXES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pos_valid,
    output logic              pos_stall,
    input  vei_pkg::vei_in_t  pos_data,
    output logic              vel_valid,
    input  logic              vel_stall,
    output vei_pkg::vei_out_t vel_data
);
    import vei_pkg::*;

    vei_in_t in_reg;
    logic    in_valid_reg;
    logic    raw_valid_reg;
    logic    out_valid_reg;
    logic    accept;
    logic    fire_diff;
    logic    fire_filt;
    sample_t pos_ax [NUM_AXES];
    sample_t vel_ax [NUM_AXES];

    assign fire_filt = raw_valid_reg && (!out_valid_reg || !vel_stall);
    assign fire_diff = in_valid_reg && (!raw_valid_reg || fire_filt);
    assign pos_stall = in_valid_reg && !fire_diff;
    assign accept    = pos_valid && !pos_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            raw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire_diff)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire_diff)
            begin
                raw_valid_reg <= 1'b1;
            end
            else if (fire_filt)
            begin
                raw_valid_reg <= 1'b0;
            end
            if (fire_filt)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!vel_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= pos_data;
        end
    end

    assign pos_ax[0] = in_reg.pos_x;
    assign pos_ax[1] = in_reg.pos_y;
    assign pos_ax[2] = in_reg.pos_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        if (a < AXES)
        begin : g_used
            raw_t raw;

            vei_diff u_diff (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (fire_diff),
                .pos   (pos_ax[a]),
                .raw   (raw)
            );

            vei_filt u_filt (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (fire_filt),
                .raw   (raw),
                .vel   (vel_ax[a])
            );
        end
        else
        begin : g_unused
            assign vel_ax[a] = '0;
        end
    end

    assign vel_valid      = out_valid_reg;
    assign vel_data.vel_x = vel_ax[0];
    assign vel_data.vel_y = vel_ax[1];
    assign vel_data.vel_z = vel_ax[2];

    // an empty input register never pushes back
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !pos_stall)
        else $error("pos_stall high with empty input register");

    // a beat in the difference stage reaches the output when it is free
    a_filt_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (raw_valid_reg && !out_valid_reg) |=> vel_valid)
        else $error("difference stage did not advance into free output");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (vel_valid && !vel_stall && !raw_valid_reg) |=> !vel_valid)
        else $error("result repeated after it was taken");

endmodule

// ===== sim/velocity_estimate_iir_checker.sv =====
`timescale 1ns / 100ps
// Checker for the velocity estimator: watches both channels, predicts each velocity beat
// and compares it field by field. Depends on vei_pkg for the beat types.
module velocity_estimate_iir_checker #(
    parameter int AXES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pos_valid,
    input  logic              pos_stall,
    input  vei_pkg::vei_in_t  pos_data,
    input  logic              vel_valid,
    input  logic              vel_stall,
    input  vei_pkg::vei_out_t vel_data,
    output int                failures,
    output int                outstanding
);

    // Q2.30 taps; the outer feed-forward tap weights raw and raw3, the inner one raw1 and raw2
    localparam longint TAP_FF_OUTER = 64'sd235794;
    localparam longint TAP_FF_INNER = 64'sd707381;
    localparam longint TAP_FB1      = 64'sd2951501526;
    localparam longint TAP_FB2      = 64'sd2714634079;
    localparam longint TAP_FB3      = 64'sd834941642;
    localparam longint DIFF_GAIN    = 64'sd500;
    localparam longint VEL_MAX      = 64'sd2147483647;
    localparam longint VEL_MIN      = -64'sd2147483648;
    localparam int     NAXIS        = 3;

    longint pos_last  [NAXIS];
    longint pos_older [NAXIS];
    longint raw_d1    [NAXIS];
    longint raw_d2    [NAXIS];
    longint raw_d3    [NAXIS];
    longint vel_d1    [NAXIS];
    longint vel_d2    [NAXIS];
    longint vel_d3    [NAXIS];

    vei_pkg::vei_out_t expected_velocity_q[$];

    // x * tap / 2^30, rounded half away from zero
    function automatic longint apply_tap(input longint x, input longint tap);
        logic [63:0]  mag_x;
        logic [63:0]  mag_t;
        logic [127:0] prod;
        longint       mag;
        mag_x = (x < 0) ? 64'(-x) : 64'(x);
        mag_t = (tap < 0) ? 64'(-tap) : 64'(tap);
        prod  = {64'd0, mag_x} * {64'd0, mag_t};
        prod  = prod + (128'd1 << 29);
        mag   = longint'({2'b00, prod[91:30]});
        return ((x < 0) != (tap < 0)) ? -mag : mag;
    endfunction

    function automatic vei_pkg::vei_out_t predict_velocity(input vei_pkg::vei_in_t s);
        vei_pkg::sample_t pos [NAXIS];
        vei_pkg::sample_t vel [NAXIS];
        longint           p;
        longint           raw;
        longint           acc;
        pos[0] = s.pos_x;
        pos[1] = s.pos_y;
        pos[2] = s.pos_z;
        for (int a = 0; a < NAXIS; a++)
        begin
            if (a >= AXES)
            begin
                vel[a] = '0;
            end
            else
            begin
                p   = pos[a];
                raw = (3 * p - 4 * pos_last[a] + pos_older[a]) * DIFF_GAIN;
                acc = apply_tap(raw + raw_d3[a], TAP_FF_OUTER)
                    + apply_tap(raw_d1[a] + raw_d2[a], TAP_FF_INNER)
                    + apply_tap(vel_d1[a], TAP_FB1)
                    - apply_tap(vel_d2[a], TAP_FB2)
                    + apply_tap(vel_d3[a], TAP_FB3);
                // clamp; the clamped value is what feeds back
                if (acc > VEL_MAX)
                    acc = VEL_MAX;
                else if (acc < VEL_MIN)
                    acc = VEL_MIN;
                pos_older[a] = pos_last[a];
                pos_last[a]  = p;
                raw_d3[a]    = raw_d2[a];
                raw_d2[a]    = raw_d1[a];
                raw_d1[a]    = raw;
                vel_d3[a]    = vel_d2[a];
                vel_d2[a]    = vel_d1[a];
                vel_d1[a]    = acc;
                vel[a]       = vei_pkg::sample_t'(acc);
            end
        end
        return '{vel[0], vel[1], vel[2]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vei_pkg::vei_out_t want;
        vei_pkg::sample_t  want_f [NAXIS];
        vei_pkg::sample_t  got_f  [NAXIS];
        string             names  [NAXIS];
        names = '{"vel_x", "vel_y", "vel_z"};
        if (!rst_n)
        begin
            for (int a = 0; a < NAXIS; a++)
            begin
                pos_last[a]  = 0;
                pos_older[a] = 0;
                raw_d1[a]    = 0;
                raw_d2[a]    = 0;
                raw_d3[a]    = 0;
                vel_d1[a]    = 0;
                vel_d2[a]    = 0;
                vel_d3[a]    = 0;
            end
            expected_velocity_q.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            // check the output beat first: it can only match an earlier sample
            if (vel_valid && !vel_stall)
            begin
                if (expected_velocity_q.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected velocity beat %h", vel_data);
                    failures++;
                end
                else
                begin
                    want      = expected_velocity_q.pop_front();
                    want_f[0] = want.vel_x;
                    want_f[1] = want.vel_y;
                    want_f[2] = want.vel_z;
                    got_f[0]  = vel_data.vel_x;
                    got_f[1]  = vel_data.vel_y;
                    got_f[2]  = vel_data.vel_z;
                    for (int a = 0; a < NAXIS; a++)
                    begin
                        if (got_f[a] !== want_f[a])
                        begin
                            if (failures < 10)
                                $display("mismatch %s: expected %0d got %0d",
                                         names[a], want_f[a], got_f[a]);
                            failures++;
                        end
                    end
                end
            end
            if (pos_valid && !pos_stall)
                expected_velocity_q.push_back(predict_velocity(pos_data));
            outstanding = expected_velocity_q.size();
        end
    end

endmodule

// ===== sim/velocity_estimate_iir_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the velocity estimator: clock, reset, position stimulus and
// output backpressure. Depends on vei_pkg, velocity_estimate_iir and the checker.
module velocity_estimate_iir_tb;

    import vei_pkg::*;

    localparam int      RANDOM_SAMPLES = 1200;
    localparam int      LIMIT_CYCLES   = 400000;
    localparam sample_t POS_MAX        = 32'sh7FFFFFFF;
    localparam sample_t POS_MIN        = 32'sh80000000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     pos_valid = 1'b0;
    logic     pos_stall;
    vei_in_t  pos_data  = '0;
    logic     vel_valid;
    logic     vel_stall = 1'b0;
    vei_out_t vel_data;

    int   failures;
    int   outstanding;
    int   send_idle = 24;
    int   recv_idle = 88;
    int   phase     = 0;
    int   cycles    = 0;
    logic long_hold = 1'b0;

    always #5 clk = ~clk;

    velocity_estimate_iir dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos_data  (pos_data),
        .vel_valid (vel_valid),
        .vel_stall (vel_stall),
        .vel_data  (vel_data)
    );

    velocity_estimate_iir_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pos_valid   (pos_valid),
        .pos_stall   (pos_stall),
        .pos_data    (pos_data),
        .vel_valid   (vel_valid),
        .vel_stall   (vel_stall),
        .vel_data    (vel_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (long_hold)
            vel_stall <= 1'b1;
        else
            vel_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // hold the output long enough for the pipeline to fill and push back
    initial
    begin
        wait (phase == 2);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (64) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic send_sample(input vei_in_t s);
        while ($urandom_range(0, 99) < send_idle)
        begin
            pos_valid <= 1'b0;
            @(posedge clk);
        end
        pos_valid <= 1'b1;
        pos_data  <= s;
        do
            @(posedge clk);
        while (pos_stall);
    endtask

    initial
    begin
        sample_t track [3];
        int      pick;
        int      span;
        track = '{default: '0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: start-up step, extremes, saturation both ways, decay, ramps
        send_sample('{32'sd0, 32'sd0, 32'sd0});
        send_sample('{POS_MAX, POS_MAX, POS_MAX});
        send_sample('{POS_MIN, POS_MIN, POS_MIN});
        send_sample('{POS_MAX, POS_MIN, 32'sd0});
        send_sample('{POS_MIN, POS_MAX, 32'sd1});
        for (int k = 0; k < 4; k++)
        begin
            send_sample('{POS_MAX, POS_MIN, POS_MAX});
            send_sample('{POS_MIN, POS_MAX, POS_MIN});
        end
        repeat (5) send_sample('{32'sd0, 32'sd0, 32'sd0});
        for (int k = 1; k <= 5; k++)
            send_sample('{sample_t'(k * 65536), sample_t'(-k * 65536), sample_t'(k)});
        send_sample('{-32'sd1, 32'sd1, -32'sd1});

        for (int ph = 0; ph < 3; ph++)
        begin
            phase     = ph;
            send_idle = (ph == 0) ? 24 : (ph == 1) ? 88 : 0;
            recv_idle = (ph == 0) ? 88 : (ph == 1) ? 24 : 0;
            for (int i = 0; i < RANDOM_SAMPLES / 3; i++)
            begin
                pick = $urandom_range(0, 99);
                for (int a = 0; a < 3; a++)
                begin
                    if (pick < 80)
                    begin
                        // smooth trajectory with a random step size
                        span     = 1 << $urandom_range(0, 18);
                        track[a] = track[a]
                                 + sample_t'(int'($urandom_range(0, 2 * span)) - span);
                    end
                    else if (pick < 88)
                    begin
                        if ($urandom_range(0, 1))
                            track[a] = sample_t'($urandom);
                    end
                    else if (pick >= 95)
                    begin
                        track[a] = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                    end
                end
                send_sample('{track[0], track[1], track[2]});
            end
        end
        pos_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
